// ===== hw/rtl/lce_pkg.sv =====
// Shared types, constants and helpers for the line clip engine.
package lce_pkg;

   localparam int MAX_REGION_RECTS = 16;
   localparam int COORD_BITS = 16;
   localparam int DIM_BITS = 13;
   localparam int COUNT_BITS = 5;
   localparam int RECT_IDX_BITS = (MAX_REGION_RECTS > 1) ? $clog2(MAX_REGION_RECTS) : 1;
   localparam int SLOT_BITS = 4;
   localparam int EXT_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
   localparam int DIFF_BITS = EXT_BITS + 1;
   localparam int FRAC_BITS = COORD_BITS;
   localparam int PROD_BITS = 2 * FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = DIM_BITS;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(480);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EXT_BITS-1:0] ext_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_REGION_ENABLE = 2'd2,
      CSR_REGION_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OPN_LOAD = 1'b0,
      OPN_DRAW = 1'b1
   } operation_type;

   typedef enum logic [1:0] {
      KIND_HSPAN = 2'd0,
      KIND_VSPAN = 2'd1,
      KIND_LINE  = 2'd2
   } kind_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
   } rect_type;

   typedef struct packed {
      ext_type l;
      ext_type t;
      ext_type r;
      ext_type b;
   } box_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] num;
      logic [FRAC_BITS-1:0] den;
   } frac_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_FIN_A,
      ST_FIN_B,
      ST_LERP_MUL,
      ST_DIV,
      ST_LERP_END,
      ST_BOX_DONE,
      ST_FETCH,
      ST_FINAL
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_WRITE_RECT,
      OP_ACCEPT,
      OP_INIT,
      OP_EDGE_A,
      OP_EDGE_B,
      OP_FIN_A,
      OP_FIN_B,
      OP_LERP_MUL,
      OP_DIV,
      OP_LERP_END,
      OP_EMIT_MISS,
      OP_EMIT_SCREEN,
      OP_START_REGIONS,
      OP_FETCH,
      OP_REGION_DONE
   } dp_op_type;

   // The flush is a region step of its own; keep it apart from the shared op codes
   typedef struct packed {
      logic kind_general;
      logic ok;
      logic edge_last;
      logic div_last;
      logic lerp_last;
      logic region_pass;
      logic region_enable;
      logic region_empty;
      logic rect_last;
   } lce_status_type;

   // Sign-extend a coordinate to box width
   function automatic ext_type ext_coord(coord_type v);
      return ext_type'({{(EXT_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
   endfunction

   // Difference of two box-width values, one bit wider
   function automatic diff_type ext_sub(ext_type a, ext_type b);
      return diff_type'({a[EXT_BITS-1], a} - {b[EXT_BITS-1], b});
   endfunction

   // Magnitude of a difference
   function automatic logic [DIFF_BITS-1:0] diff_mag(diff_type v);
      return v[DIFF_BITS-1] ? (~v + DIFF_BITS'(1)) : v;
   endfunction

endpackage

// ===== hw/rtl/lce_ctrl.sv =====
// Sequencer for the line clip engine: steps the datapath through each clip pass.
module lce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_operation,
   input  lce_pkg::lce_status_type  status,
   output logic                     busy,
   output logic                     flush,
   output lce_pkg::dp_op_type       op
);
   import lce_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Hold or advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_operation == OPN_DRAW) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = status.kind_general ? ST_EDGE_A : ST_BOX_DONE;
         end
         ST_EDGE_A: state_in = ST_EDGE_B;
         ST_EDGE_B: begin
            state_in = status.edge_last ? ST_FIN_A : ST_EDGE_A;
         end
         ST_FIN_A: state_in = ST_FIN_B;
         ST_FIN_B: state_in = ST_LERP_MUL;
         ST_LERP_MUL: begin
            state_in = status.ok ? ST_DIV : ST_BOX_DONE;
         end
         ST_DIV: begin
            state_in = status.div_last ? ST_LERP_END : ST_DIV;
         end
         ST_LERP_END: begin
            state_in = status.lerp_last ? ST_BOX_DONE : ST_LERP_MUL;
         end
         ST_BOX_DONE: begin
            if (!status.region_pass) begin
               if (!status.ok || !status.region_enable || status.region_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end else begin
               state_in = status.rect_last ? ST_FINAL : ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_INIT;
         ST_FINAL: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      op = OP_NONE;
      flush = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op = (req_operation == OPN_DRAW) ? OP_ACCEPT : OP_WRITE_RECT;
            end
         end
         ST_INIT: op = OP_INIT;
         ST_EDGE_A: op = OP_EDGE_A;
         ST_EDGE_B: op = OP_EDGE_B;
         ST_FIN_A: op = OP_FIN_A;
         ST_FIN_B: op = OP_FIN_B;
         ST_LERP_MUL: op = status.ok ? OP_LERP_MUL : OP_NONE;
         ST_DIV: op = OP_DIV;
         ST_LERP_END: op = OP_LERP_END;
         ST_BOX_DONE: begin
            if (!status.region_pass) begin
               if (!status.ok || (status.region_enable && status.region_empty)) begin
                  op = OP_EMIT_MISS;
               end else if (!status.region_enable) begin
                  op = OP_EMIT_SCREEN;
               end else begin
                  op = OP_START_REGIONS;
               end
            end else begin
               op = OP_REGION_DONE;
            end
         end
         ST_FETCH: op = OP_FETCH;
         ST_FINAL: flush = 1'b1;
         default: op = OP_NONE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/lce_datapath.sv =====
// Datapath of the line clip engine: region table, clip arithmetic, divider, result register.
module lce_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  lce_pkg::dp_op_type              op,
   input  logic                            flush,
   output lce_pkg::lce_status_type         status,
   input  logic [lce_pkg::DIM_BITS-1:0]    screen_width,
   input  logic [lce_pkg::DIM_BITS-1:0]    screen_height,
   input  logic                            region_enable,
   input  logic [lce_pkg::COUNT_BITS-1:0]  region_count,
   input  logic [lce_pkg::SLOT_BITS-1:0]   req_rect_index,
   input  lce_pkg::coord_type              req_rect_left,
   input  lce_pkg::coord_type              req_rect_top,
   input  lce_pkg::coord_type              req_rect_right,
   input  lce_pkg::coord_type              req_rect_bottom,
   input  lce_pkg::coord_type              req_line_x1,
   input  lce_pkg::coord_type              req_line_y1,
   input  lce_pkg::coord_type              req_line_x2,
   input  lce_pkg::coord_type              req_line_y2,
   output logic                            rsp_strobe,
   output lce_pkg::coord_type              rsp_seg_x1,
   output lce_pkg::coord_type              rsp_seg_y1,
   output lce_pkg::coord_type              rsp_seg_x2,
   output lce_pkg::coord_type              rsp_seg_y2,
   output logic [1:0]                      rsp_seg_kind,
   output logic                            rsp_visible,
   output logic                            rsp_last
);
   import lce_pkg::*;

   typedef struct packed {
      coord_type [3:0]              s;
      kind_type                     kind;
      logic                         region_pass;
      frac_type                     u1;
      frac_type                     u2;
      logic [1:0]                   edge_idx;
      logic [1:0]                   lerp;
      logic                         ok;
      frac_type                     cand;
      logic                         cand_act;
      logic                         cand_low;
      logic [PROD_BITS-1:0]         prod_a;
      logic [FRAC_BITS-1:0]         div_r;
      logic [FRAC_BITS-1:0]         div_q;
      logic [DIV_CNT_BITS-1:0]      div_cnt;
      coord_type [3:0]              o;
      logic [RECT_IDX_BITS-1:0]     rect;
      coord_type [3:0]              pend;
      logic                         pend_valid;
   } work_type;

   typedef struct packed {
      logic                         strobe;
      coord_type [3:0]              seg;
      kind_type                     kind;
      logic                         visible;
      logic                         last;
   } out_type;

   work_type work_ff, work_in;
   out_type  rsp_ff, rsp_in;

   rect_type rect_mem [MAX_REGION_RECTS];
   rect_type rect_rd_ff;

   box_type                 box;
   ext_type                 s0, s1, s2, s3;
   diff_type                dx, dy, p, q;
   logic [DIFF_BITS-1:0]    p_mag, q_mag, d_mag;
   logic                    c_act, c_low, c_rej;
   logic [FRAC_BITS-1:0]    mul_a, mul_b;
   logic [PROD_BITS-1:0]    mul_res;
   kind_type                kind_new;
   coord_type [3:0]         s_new;
   ext_type                 iv_a, iv_b, iv_pos, iv_rl, iv_rh, iv_pl, iv_ph, iv_oa, iv_ob;
   logic                    iv_ok;
   coord_type [3:0]         iv_o;
   diff_type                d_sel, a_sel, q_ext, base;
   frac_type                u_sel;
   logic [FRAC_BITS:0]      div_t, div_d;
   logic                    div_ge;
   coord_type               lerp_res;
   logic [COUNT_BITS-1:0]   n_rects;

   // Box under test: screen on the first pass, a table entry afterwards
   always_comb begin
      if (work_ff.region_pass) begin
         box.l = ext_coord(rect_rd_ff.l);
         box.t = ext_coord(rect_rd_ff.t);
         box.r = ext_coord(rect_rd_ff.r);
         box.b = ext_coord(rect_rd_ff.b);
      end else begin
         box.l = '0;
         box.t = '0;
         box.r = ext_type'({{(EXT_BITS-DIM_BITS){1'b0}}, screen_width}) - ext_type'(1);
         box.b = ext_type'({{(EXT_BITS-DIM_BITS){1'b0}}, screen_height}) - ext_type'(1);
      end
   end

   // Classify the incoming line and order span ends
   always_comb begin
      s_new[0] = req_line_x1;
      s_new[1] = req_line_y1;
      s_new[2] = req_line_x2;
      s_new[3] = req_line_y2;
      kind_new = KIND_LINE;
      if (req_line_x1 == req_line_x2) begin
         kind_new = KIND_VSPAN;
         if (req_line_y1 > req_line_y2) begin
            s_new[1] = req_line_y2;
            s_new[3] = req_line_y1;
         end
      end else if (req_line_y1 == req_line_y2) begin
         kind_new = KIND_HSPAN;
         if (req_line_x1 > req_line_x2) begin
            s_new[0] = req_line_x2;
            s_new[2] = req_line_x1;
         end
      end
   end

   // Edge terms p and q for the current boundary
   always_comb begin
      s0 = ext_coord(work_ff.s[0]);
      s1 = ext_coord(work_ff.s[1]);
      s2 = ext_coord(work_ff.s[2]);
      s3 = ext_coord(work_ff.s[3]);
      dx = ext_sub(s2, s0);
      dy = ext_sub(s3, s1);
      case (work_ff.edge_idx)
         2'd0: begin
            p = -dx;
            q = ext_sub(s0, box.l);
         end
         2'd1: begin
            p = dx;
            q = ext_sub(box.r, s0);
         end
         2'd2: begin
            p = -dy;
            q = ext_sub(s1, box.t);
         end
         default: begin
            p = dy;
            q = ext_sub(box.b, s1);
         end
      endcase
      p_mag = diff_mag(p);
      q_mag = diff_mag(q);
   end

   // Decide what the boundary does to the parameter window
   always_comb begin
      c_act = 1'b0;
      c_low = 1'b0;
      c_rej = 1'b0;
      if (p == '0) begin
         c_rej = q[DIFF_BITS-1];
      end else if (p[DIFF_BITS-1]) begin
         if (q[DIFF_BITS-1]) begin
            if (q_mag > p_mag) begin
               c_rej = 1'b1;
            end else begin
               c_act = 1'b1;
               c_low = 1'b1;
            end
         end
      end else begin
         if (q[DIFF_BITS-1]) begin
            c_rej = 1'b1;
         end else if (q_mag < p_mag) begin
            c_act = 1'b1;
         end
      end
   end

   // Span clipping against the box
   always_comb begin
      if (work_ff.kind == KIND_VSPAN) begin
         iv_a = s1;
         iv_b = s3;
         iv_pos = s0;
         iv_rl = box.t;
         iv_rh = box.b;
         iv_pl = box.l;
         iv_ph = box.r;
      end else begin
         iv_a = s0;
         iv_b = s2;
         iv_pos = s1;
         iv_rl = box.l;
         iv_rh = box.r;
         iv_pl = box.t;
         iv_ph = box.b;
      end
      iv_oa = (iv_a > iv_rl) ? iv_a : iv_rl;
      iv_ob = (iv_b < iv_rh) ? iv_b : iv_rh;
      iv_ok = !(iv_pos < iv_pl || iv_pos > iv_ph || iv_a > iv_rh || iv_b < iv_rl)
              && (iv_oa <= iv_ob);
      iv_o = work_ff.s;
      if (work_ff.kind == KIND_VSPAN) begin
         iv_o[1] = iv_oa[COORD_BITS-1:0];
         iv_o[3] = iv_ob[COORD_BITS-1:0];
      end else begin
         iv_o[0] = iv_oa[COORD_BITS-1:0];
         iv_o[2] = iv_ob[COORD_BITS-1:0];
         iv_o[3] = work_ff.s[1];
      end
   end

   // Interpolation operands and restoring divide step
   always_comb begin
      u_sel = work_ff.lerp[1] ? work_ff.u2 : work_ff.u1;
      d_sel = work_ff.lerp[0] ? dy : dx;
      a_sel = work_ff.lerp[0] ? diff_type'({s1[EXT_BITS-1], s1})
                              : diff_type'({s0[EXT_BITS-1], s0});
      d_mag = diff_mag(d_sel);
      div_t = {work_ff.div_r, work_ff.div_q[FRAC_BITS-1]};
      div_d = {1'b0, u_sel.den};
      div_ge = (div_t >= div_d);
      q_ext = diff_type'({{(DIFF_BITS-FRAC_BITS){1'b0}}, work_ff.div_q});
      if (!d_sel[DIFF_BITS-1] && d_sel != '0) begin
         base = a_sel + q_ext;
         if (work_ff.div_r != '0 && base[DIFF_BITS-1]) begin
            base = base + diff_type'(1);
         end
      end else begin
         base = a_sel - q_ext;
         if (work_ff.div_r != '0 && !base[DIFF_BITS-1] && base != '0) begin
            base = base - diff_type'(1);
         end
      end
      lerp_res = base[COORD_BITS-1:0];
   end

   // Share one multiplier among the compare and interpolation steps
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_EDGE_A: begin
            mul_a = c_low ? work_ff.u1.num : work_ff.u2.num;
            mul_b = p_mag[FRAC_BITS-1:0];
         end
         OP_EDGE_B: begin
            mul_a = work_ff.cand.num;
            mul_b = work_ff.cand_low ? work_ff.u1.den : work_ff.u2.den;
         end
         OP_FIN_A: begin
            mul_a = work_ff.u2.num;
            mul_b = work_ff.u1.den;
         end
         OP_FIN_B: begin
            mul_a = work_ff.u1.num;
            mul_b = work_ff.u2.den;
         end
         OP_LERP_MUL: begin
            mul_a = u_sel.num;
            mul_b = d_mag[FRAC_BITS-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;

   // Work register updates
   always_comb begin
      work_in = work_ff;
      rsp_in = rsp_ff;
      rsp_in.strobe = 1'b0;
      case (op)
         OP_ACCEPT: begin
            work_in.s = s_new;
            work_in.kind = kind_new;
            work_in.region_pass = 1'b0;
            work_in.pend_valid = 1'b0;
         end
         OP_INIT: begin
            work_in.u1.num = '0;
            work_in.u1.den = FRAC_BITS'(1);
            work_in.u2.num = FRAC_BITS'(1);
            work_in.u2.den = FRAC_BITS'(1);
            work_in.edge_idx = '0;
            work_in.lerp = '0;
            work_in.ok = 1'b1;
            if (work_ff.kind != KIND_LINE) begin
               work_in.ok = iv_ok;
               work_in.o = iv_o;
            end
         end
         OP_EDGE_A: begin
            work_in.prod_a = mul_res;
            work_in.cand.num = q_mag[FRAC_BITS-1:0];
            work_in.cand.den = p_mag[FRAC_BITS-1:0];
            work_in.cand_act = c_act;
            work_in.cand_low = c_low;
            if (c_rej) begin
               work_in.ok = 1'b0;
            end
         end
         OP_EDGE_B: begin
            if (work_ff.cand_act) begin
               if (work_ff.cand_low && work_ff.prod_a < mul_res) begin
                  work_in.u1 = work_ff.cand;
               end
               if (!work_ff.cand_low && mul_res < work_ff.prod_a) begin
                  work_in.u2 = work_ff.cand;
               end
            end
            work_in.edge_idx = work_ff.edge_idx + 2'd1;
         end
         OP_FIN_A: work_in.prod_a = mul_res;
         OP_FIN_B: begin
            if (work_ff.prod_a < mul_res) begin
               work_in.ok = 1'b0;
            end
         end
         OP_LERP_MUL: begin
            work_in.div_r = mul_res[PROD_BITS-1:FRAC_BITS];
            work_in.div_q = mul_res[FRAC_BITS-1:0];
            work_in.div_cnt = '0;
         end
         OP_DIV: begin
            work_in.div_r = div_ge ? FRAC_BITS'(div_t - div_d) : div_t[FRAC_BITS-1:0];
            work_in.div_q = {work_ff.div_q[FRAC_BITS-2:0], div_ge};
            work_in.div_cnt = work_ff.div_cnt + DIV_CNT_BITS'(1);
         end
         OP_LERP_END: begin
            work_in.o[work_ff.lerp] = lerp_res;
            work_in.lerp = work_ff.lerp + 2'd1;
         end
         OP_EMIT_MISS: begin
            rsp_in.strobe = 1'b1;
            rsp_in.seg = '0;
            rsp_in.kind = work_ff.kind;
            rsp_in.visible = 1'b0;
            rsp_in.last = 1'b1;
         end
         OP_EMIT_SCREEN: begin
            rsp_in.strobe = 1'b1;
            rsp_in.seg = work_ff.o;
            rsp_in.kind = work_ff.kind;
            rsp_in.visible = 1'b1;
            rsp_in.last = 1'b1;
         end
         OP_START_REGIONS: begin
            work_in.s = work_ff.o;
            work_in.region_pass = 1'b1;
            work_in.rect = '0;
         end
         OP_REGION_DONE: begin
            // Release the previous hit; hold this one until the scan ends
            if (work_ff.ok) begin
               if (work_ff.pend_valid) begin
                  rsp_in.strobe = 1'b1;
                  rsp_in.seg = work_ff.pend;
                  rsp_in.kind = work_ff.kind;
                  rsp_in.visible = 1'b1;
                  rsp_in.last = 1'b0;
               end
               work_in.pend = work_ff.o;
               work_in.pend_valid = 1'b1;
            end
            work_in.rect = work_ff.rect + RECT_IDX_BITS'(1);
         end
         default: begin
            work_in = work_ff;
         end
      endcase
      // Close the scan with the held hit, or a miss when nothing was hit
      if (flush) begin
         rsp_in.strobe = 1'b1;
         rsp_in.kind = work_ff.kind;
         rsp_in.last = 1'b1;
         rsp_in.visible = work_ff.pend_valid;
         rsp_in.seg = work_ff.pend_valid ? work_ff.pend : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.pend_valid <= 1'b0;
         work_ff.region_pass <= 1'b0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         work_ff <= work_in;
         rsp_ff <= rsp_in;
      end
   end

   // Region table: write on a load transfer, registered read on fetch
   always_ff @(posedge clock) begin
      if (op == OP_WRITE_RECT && int'(req_rect_index) < MAX_REGION_RECTS) begin
         rect_mem[req_rect_index[RECT_IDX_BITS-1:0]] <=
            '{l: req_rect_left, t: req_rect_top, r: req_rect_right, b: req_rect_bottom};
      end
      if (op == OP_FETCH) begin
         rect_rd_ff <= rect_mem[work_ff.rect];
      end
   end

   // Status for the sequencer
   always_comb begin
      n_rects = (int'(region_count) > MAX_REGION_RECTS) ? COUNT_BITS'(MAX_REGION_RECTS)
                                                        : region_count;
      status.kind_general = (work_ff.kind == KIND_LINE);
      status.ok = work_ff.ok;
      status.edge_last = (work_ff.edge_idx == 2'd3);
      status.div_last = (int'(work_ff.div_cnt) == FRAC_BITS - 1);
      status.lerp_last = (work_ff.lerp == 2'd3);
      status.region_pass = work_ff.region_pass;
      status.region_enable = region_enable;
      status.region_empty = (region_count == '0);
      status.rect_last = (int'(work_ff.rect) == int'(n_rects) - 1);
   end

   assign rsp_strobe = rsp_ff.strobe;
   assign rsp_seg_x1 = rsp_ff.seg[0];
   assign rsp_seg_y1 = rsp_ff.seg[1];
   assign rsp_seg_x2 = rsp_ff.seg[2];
   assign rsp_seg_y2 = rsp_ff.seg[3];
   assign rsp_seg_kind = rsp_ff.kind;
   assign rsp_visible = rsp_ff.visible;
   assign rsp_last = rsp_ff.last;

endmodule

// ===== hw/rtl/line_clip_engine_unit.sv =====
// Line clip engine top level: configuration registers, sequencer and datapath.
// A load transfer (operation 0) writes one region rectangle in the cycle it is taken and
// leaves busy low. A draw transfer raises busy and clips the line first to the screen and
// then, with regions enabled, to each of the first region_count table rectangles (at most
// 16) in turn. Each clip pass of a general line runs the Liang-Barsky boundary tests on one
// shared 16x16 multiplier, then four end-point interpolations, each through a restoring
// divider that yields one quotient bit a cycle. A horizontal or vertical span is clipped
// as an interval instead. Results leave one per strobe cycle and cannot be held off; the
// final one carries last, and a line that misses gives one result with visible low.
// Configuration must be written only while busy is low; the block does not enforce this.
module line_clip_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [lce_pkg::SLOT_BITS-1:0]       req_rect_index,
   input  lce_pkg::coord_type                  req_rect_left,
   input  lce_pkg::coord_type                  req_rect_top,
   input  lce_pkg::coord_type                  req_rect_right,
   input  lce_pkg::coord_type                  req_rect_bottom,
   input  lce_pkg::coord_type                  req_line_x1,
   input  lce_pkg::coord_type                  req_line_y1,
   input  lce_pkg::coord_type                  req_line_x2,
   input  lce_pkg::coord_type                  req_line_y2,
   output logic                                rsp_strobe,
   output lce_pkg::coord_type                  rsp_seg_x1,
   output lce_pkg::coord_type                  rsp_seg_y1,
   output lce_pkg::coord_type                  rsp_seg_x2,
   output lce_pkg::coord_type                  rsp_seg_y2,
   output logic [1:0]                          rsp_seg_kind,
   output logic                                rsp_visible,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [lce_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lce_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import lce_pkg::*;

   logic [DIM_BITS-1:0]    screen_width_ff, screen_width_in;
   logic [DIM_BITS-1:0]    screen_height_ff, screen_height_in;
   logic                   region_enable_ff, region_enable_in;
   logic [COUNT_BITS-1:0]  region_count_ff, region_count_in;
   lce_status_type         status;
   dp_op_type              op;
   logic                   flush;

   // Register writes
   always_comb begin
      screen_width_in = screen_width_ff;
      screen_height_in = screen_height_ff;
      region_enable_in = region_enable_ff;
      region_count_in = region_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: screen_width_in = csr_write_data;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_write_data;
            CSR_REGION_ENABLE: region_enable_in = csr_write_data[0];
            CSR_REGION_COUNT: region_count_in = csr_write_data[COUNT_BITS-1:0];
            default: region_count_in = region_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         region_enable_ff <= 1'b0;
         region_count_ff <= '0;
      end else begin
         screen_width_ff <= screen_width_in;
         screen_height_ff <= screen_height_in;
         region_enable_ff <= region_enable_in;
         region_count_ff <= region_count_in;
      end
   end

   lce_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .busy          (busy),
      .flush         (flush),
      .op            (op)
   );

   lce_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .flush           (flush),
      .status          (status),
      .screen_width    (screen_width_ff),
      .screen_height   (screen_height_ff),
      .region_enable   (region_enable_ff),
      .region_count    (region_count_ff),
      .req_rect_index  (req_rect_index),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_right  (req_rect_right),
      .req_rect_bottom (req_rect_bottom),
      .req_line_x1     (req_line_x1),
      .req_line_y1     (req_line_y1),
      .req_line_x2     (req_line_x2),
      .req_line_y2     (req_line_y2),
      .rsp_strobe      (rsp_strobe),
      .rsp_seg_x1      (rsp_seg_x1),
      .rsp_seg_y1      (rsp_seg_y1),
      .rsp_seg_x2      (rsp_seg_x2),
      .rsp_seg_y2      (rsp_seg_y2),
      .rsp_seg_kind    (rsp_seg_kind),
      .rsp_visible     (rsp_visible),
      .rsp_last        (rsp_last)
   );

   // A result transfer only follows a cycle of draw work
   a_strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without draw work");

   // A draw never ends without its final result
   a_end_has_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_last))
      else $error("draw finished without a last result");

   // A miss is always the only and so the final result
   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_visible) |-> rsp_last)
      else $error("invisible result not marked last");

endmodule

// ===== tb/lce_checker.sv =====
// Line clip engine checker: mirrors registers and table, predicts results and compares them.
module lce_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_operation,
   input  logic [lce_pkg::SLOT_BITS-1:0]       req_rect_index,
   input  lce_pkg::coord_type                  req_rect_left,
   input  lce_pkg::coord_type                  req_rect_top,
   input  lce_pkg::coord_type                  req_rect_right,
   input  lce_pkg::coord_type                  req_rect_bottom,
   input  lce_pkg::coord_type                  req_line_x1,
   input  lce_pkg::coord_type                  req_line_y1,
   input  lce_pkg::coord_type                  req_line_x2,
   input  lce_pkg::coord_type                  req_line_y2,
   input  logic                                rsp_strobe,
   input  lce_pkg::coord_type                  rsp_seg_x1,
   input  lce_pkg::coord_type                  rsp_seg_y1,
   input  lce_pkg::coord_type                  rsp_seg_x2,
   input  lce_pkg::coord_type                  rsp_seg_y2,
   input  logic [1:0]                          rsp_seg_kind,
   input  logic                                rsp_visible,
   input  logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [lce_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lce_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  segment_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lce_pkg::*;

   typedef longint quad_type [4];

   typedef struct {
      coord_type  x1;
      coord_type  y1;
      coord_type  x2;
      coord_type  y2;
      logic [1:0] kind;
      logic       visible;
      logic       last;
   } segment_type;

   segment_type segment_queue[$];

   // Mirrored registers and region table
   longint      scr_width;
   longint      scr_height;
   logic        reg_enable;
   int          reg_count;
   longint      tab_l [MAX_REGION_RECTS];
   longint      tab_t [MAX_REGION_RECTS];
   longint      tab_r [MAX_REGION_RECTS];
   longint      tab_b [MAX_REGION_RECTS];

   // Exact interpolation a + (n/den)*d, truncated toward zero
   function automatic longint interp(longint a, longint d, longint n, longint den);
      if (d == 0) return a;
      return (a * den + d * n) / den;
   endfunction

   // Liang-Barsky clip against one box with exact rational parameters
   function automatic bit clip_line(longint l, longint t, longint r, longint b,
                                    quad_type s, output quad_type o);
      longint dx, dy, un, ud, u1n, u1d, u2n, u2d;
      longint p [4];
      longint q [4];
      dx = s[2] - s[0];
      dy = s[3] - s[1];
      p[0] = -dx; q[0] = s[0] - l;
      p[1] = dx;  q[1] = r - s[0];
      p[2] = -dy; q[2] = s[1] - t;
      p[3] = dy;  q[3] = b - s[1];
      u1n = 0; u1d = 1; u2n = 1; u2d = 1;
      o = '{0, 0, 0, 0};
      for (int i = 0; i < 4; i++) begin
         if (p[i] == 0) begin
            if (q[i] < 0) return 0;
         end else if (p[i] < 0) begin
            if (q[i] < 0) begin
               un = -q[i];
               ud = -p[i];
               if (un > ud) return 0;
               if (u1n * ud < un * u1d) begin
                  u1n = un;
                  u1d = ud;
               end
            end
         end else begin
            if (q[i] < 0) return 0;
            if (q[i] < p[i] && q[i] * u2d < u2n * p[i]) begin
               u2n = q[i];
               u2d = p[i];
            end
         end
      end
      if (u2n * u1d < u1n * u2d) return 0;
      o[0] = interp(s[0], dx, u1n, u1d);
      o[1] = interp(s[1], dy, u1n, u1d);
      o[2] = interp(s[0], dx, u2n, u2d);
      o[3] = interp(s[1], dy, u2n, u2d);
      return 1;
   endfunction

   // Clip a span as an interval or a general line, by kind
   function automatic bit clip_box(longint l, longint t, longint r, longint b,
                                   kind_type kind, quad_type s, output quad_type o);
      o = '{0, 0, 0, 0};
      case (kind)
         KIND_HSPAN: begin
            o[1] = s[1];
            o[3] = s[1];
            if (s[1] < t || s[1] > b || s[0] > r || s[2] < l) return 0;
            o[0] = (s[0] > l) ? s[0] : l;
            o[2] = (s[2] < r) ? s[2] : r;
            return o[0] <= o[2];
         end
         KIND_VSPAN: begin
            o[0] = s[0];
            o[2] = s[0];
            if (s[0] < l || s[0] > r || s[1] > b || s[3] < t) return 0;
            o[1] = (s[1] > t) ? s[1] : t;
            o[3] = (s[3] < b) ? s[3] : b;
            return o[1] <= o[3];
         end
         default: return clip_line(l, t, r, b, s, o);
      endcase
   endfunction

   // Queue the segments one draw transfer gives
   function automatic void predict_segments(longint x1, longint y1, longint x2, longint y2);
      quad_type    ln, scr, seg;
      kind_type    kind;
      longint      tmp;
      int          limit, first;
      segment_type item;
      ln = '{x1, y1, x2, y2};
      if (x1 == x2) begin
         kind = KIND_VSPAN;
         if (ln[1] > ln[3]) begin tmp = ln[1]; ln[1] = ln[3]; ln[3] = tmp; end
      end else if (y1 == y2) begin
         kind = KIND_HSPAN;
         if (ln[0] > ln[2]) begin tmp = ln[0]; ln[0] = ln[2]; ln[2] = tmp; end
      end else begin
         kind = KIND_LINE;
      end
      first = segment_queue.size();
      item.kind = kind;
      item.visible = 1'b1;
      item.last = 1'b0;
      if (clip_box(0, 0, scr_width - 1, scr_height - 1, kind, ln, scr)) begin
         if (!reg_enable) begin
            item.x1 = coord_type'(scr[0]); item.y1 = coord_type'(scr[1]);
            item.x2 = coord_type'(scr[2]); item.y2 = coord_type'(scr[3]);
            segment_queue.push_back(item);
         end else begin
            limit = (reg_count < MAX_REGION_RECTS) ? reg_count : MAX_REGION_RECTS;
            for (int i = 0; i < limit && segment_queue.size() - first < 16; i++) begin
               if (clip_box(tab_l[i], tab_t[i], tab_r[i], tab_b[i], kind, scr, seg)) begin
                  item.x1 = coord_type'(seg[0]); item.y1 = coord_type'(seg[1]);
                  item.x2 = coord_type'(seg[2]); item.y2 = coord_type'(seg[3]);
                  segment_queue.push_back(item);
               end
            end
         end
      end
      // A miss gives one blank, invisible result
      if (segment_queue.size() == first) begin
         item.x1 = '0; item.y1 = '0; item.x2 = '0; item.y2 = '0;
         item.visible = 1'b0;
         segment_queue.push_back(item);
      end
      segment_queue[segment_queue.size() - 1].last = 1'b1;
   endfunction

   task automatic note_error(string msg);
      if (error_count < 10) $display("%0t: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Watch the channels, predict each transfer and compare results
   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         scr_width = longint'(SCREEN_WIDTH_RESET);
         scr_height = longint'(SCREEN_HEIGHT_RESET);
         reg_enable = 1'b0;
         reg_count = 0;
         segment_queue.delete();
         error_count = 0;
         segment_count = 0;
      end else begin
         if (rsp_strobe) begin
            segment_count++;
            if (segment_queue.size() == 0) begin
               note_error("result with nothing expected");
            end else begin
               want = segment_queue.pop_front();
               if (rsp_seg_x1 !== want.x1 || rsp_seg_y1 !== want.y1 ||
                   rsp_seg_x2 !== want.x2 || rsp_seg_y2 !== want.y2 ||
                   rsp_seg_kind !== want.kind || rsp_visible !== want.visible ||
                   rsp_last !== want.last)
                  note_error($sformatf(
                     "exp (%0d,%0d)-(%0d,%0d) k%0d v%0b l%0b got (%0d,%0d)-(%0d,%0d) k%0d v%0b l%0b",
                     want.x1, want.y1, want.x2, want.y2, want.kind, want.visible, want.last,
                     rsp_seg_x1, rsp_seg_y1, rsp_seg_x2, rsp_seg_y2, rsp_seg_kind,
                     rsp_visible, rsp_last));
            end
         end
         if (start && !busy) begin
            if (req_operation == OPN_LOAD) begin
               tab_l[req_rect_index] = longint'(req_rect_left);
               tab_t[req_rect_index] = longint'(req_rect_top);
               tab_r[req_rect_index] = longint'(req_rect_right);
               tab_b[req_rect_index] = longint'(req_rect_bottom);
            end else begin
               predict_segments(longint'(req_line_x1), longint'(req_line_y1),
                                longint'(req_line_x2), longint'(req_line_y2));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  scr_width = longint'(csr_write_data);
               CSR_SCREEN_HEIGHT: scr_height = longint'(csr_write_data);
               CSR_REGION_ENABLE: reg_enable = csr_write_data[0];
               CSR_REGION_COUNT:  reg_count = int'(csr_write_data[COUNT_BITS-1:0]);
               default: ;
            endcase
         end
      end
      pending_count = segment_queue.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the line clip engine: clock, reset, stimulus, watchdog and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lce_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      operation_type         op;
      logic [SLOT_BITS-1:0]  idx;
      coord_type             rl, rt, rr, rb;
      coord_type             x1, y1, x2, y2;
   } item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [SLOT_BITS-1:0] req_rect_index = '0;
   coord_type req_rect_left = '0, req_rect_top = '0, req_rect_right = '0, req_rect_bottom = '0;
   coord_type req_line_x1 = '0, req_line_y1 = '0, req_line_x2 = '0, req_line_y2 = '0;
   logic rsp_strobe;
   coord_type rsp_seg_x1, rsp_seg_y1, rsp_seg_x2, rsp_seg_y2;
   logic [1:0] rsp_seg_kind;
   logic rsp_visible, rsp_last;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   int error_count, pending_count, segment_count;
   int idle_cycles = 0;
   int sent_items = 0;
   int sent_draws = 0;
   int phase_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   line_clip_engine_unit u_dut (.*);

   lce_checker u_checker (.*);

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one item, optionally after a random gap, and hold until the transfer
   task automatic send_item(item_type it, bit may_idle);
      if (may_idle && $urandom_range(0, 99) < 38) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_operation <= it.op;
      req_rect_index <= it.idx;
      req_rect_left <= it.rl;
      req_rect_top <= it.rt;
      req_rect_right <= it.rr;
      req_rect_bottom <= it.rb;
      req_line_x1 <= it.x1;
      req_line_y1 <= it.y1;
      req_line_x2 <= it.x2;
      req_line_y2 <= it.y2;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_items++;
      if (it.op == OPN_DRAW) sent_draws++;
   endtask

   // Drop start and wait until every result is out and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write all four registers; only called while idle
   task automatic set_config(int w, int h, int en, int cnt);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;  csr_write_data <= CSR_DATA_BITS'(w);   @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT; csr_write_data <= CSR_DATA_BITS'(h);   @(posedge clock);
      csr_index <= CSR_REGION_ENABLE; csr_write_data <= CSR_DATA_BITS'(en);  @(posedge clock);
      csr_index <= CSR_REGION_COUNT;  csr_write_data <= CSR_DATA_BITS'(cnt); @(posedge clock);
      csr_write_enable <= 1'b0;
      phase_count++;
   endtask

   function automatic item_type draw(int x1, int y1, int x2, int y2);
      item_type it;
      it.op = OPN_DRAW;
      it.idx = SLOT_BITS'($urandom);
      it.rl = coord_type'($urandom); it.rt = coord_type'($urandom);
      it.rr = coord_type'($urandom); it.rb = coord_type'($urandom);
      it.x1 = coord_type'(x1); it.y1 = coord_type'(y1);
      it.x2 = coord_type'(x2); it.y2 = coord_type'(y2);
      return it;
   endfunction

   function automatic item_type load(int idx, int l, int t, int r, int b);
      item_type it;
      it.op = OPN_LOAD;
      it.idx = SLOT_BITS'(idx);
      it.rl = coord_type'(l); it.rt = coord_type'(t);
      it.rr = coord_type'(r); it.rb = coord_type'(b);
      it.x1 = coord_type'($urandom); it.y1 = coord_type'($urandom);
      it.x2 = coord_type'($urandom); it.y2 = coord_type'($urandom);
      return it;
   endfunction

   // Mostly near the screen, sometimes anywhere in the coordinate range
   function automatic int rand_coord();
      if ($urandom_range(0, 9) < 3) return int'(coord_type'($urandom));
      return int'($urandom_range(0, 1400)) - 300;
   endfunction

   function automatic item_type random_draw();
      int x1, y1, x2, y2;
      x1 = rand_coord(); y1 = rand_coord(); x2 = rand_coord(); y2 = rand_coord();
      case ($urandom_range(0, 9))
         0, 1: x2 = x1;
         2, 3: y2 = y1;
         4: begin x2 = x1; y2 = y1; end
         default: ;
      endcase
      return draw(x1, y1, x2, y2);
   endfunction

   function automatic item_type random_load(int idx);
      int a, b, c, d;
      a = rand_coord(); b = rand_coord(); c = rand_coord(); d = rand_coord();
      // Mostly well-ordered boxes, the rest inverted or arbitrary
      if ($urandom_range(0, 99) < 70) begin
         if (a > c) begin a = a + c; c = a - c; a = a - c; end
         if (b > d) begin b = b + d; d = b - d; b = b - d; end
      end
      return load(idx, a, b, c, d);
   endfunction

   function automatic int rand_dim();
      case ($urandom_range(0, 5))
         0: return 1;
         1: return 4096;
         2: return 8191;
         3: return 0;
         default: return int'($urandom_range(1, 4096));
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, screen only
      send_item(draw(-100, -50, 900, 700), 0);
      send_item(draw(700, 10, -5, 10), 0);
      send_item(draw(20, 500, 20, -3), 0);
      send_item(draw(5, 5, 5, 5), 0);
      send_item(draw(-7, 900, -7, 900), 0);
      send_item(draw(-10, -10, -1, -20), 0);
      send_item(draw(-32768, -32768, 32767, 32767), 0);
      send_item(draw(32767, -32768, -32768, 32767), 0);
      send_item(load(0, 0, 0, 99, 99), 0);
      send_item(load(1, 50, 50, 300, 200), 0);
      send_item(load(2, 200, 200, 100, 100), 0);
      send_item(load(3, -32768, -32768, 32767, 32767), 0);
      drain();
      set_config(640, 480, 1, 4);
      send_item(draw(-20, -40, 700, 300), 0);
      send_item(draw(-100, 150, 900, 150), 0);
      send_item(draw(150, 900, 150, -100), 0);
      drain();
      set_config(640, 480, 1, 0);
      send_item(draw(0, 0, 100, 50), 0);
      drain();
      set_config(1, 1, 0, 0);
      send_item(draw(0, 0, 0, 0), 0);
      send_item(draw(-3, -3, 4, 4), 0);
      drain();
      set_config(0, 8191, 0, 0);
      send_item(draw(0, 0, 10, 10), 0);
      drain();

      // Random: fill the whole table, then several register settings
      set_config(640, 480, 0, 0);
      for (int i = 0; i < MAX_REGION_RECTS; i++) send_item(random_load(i), 1);
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: set_config(4096, 4096, 1, 16);
            1: set_config(640, 480, 1, 31);
            2: set_config(rand_dim(), rand_dim(), 0, int'($urandom_range(0, 31)));
            default: set_config(rand_dim(), rand_dim(), int'($urandom_range(0, 1)),
                                int'($urandom_range(0, 31)));
         endcase
         for (int k = 0; k < 14; k++) begin
            // Hold off once until everything is out
            if (ph == 3 && k == 7) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 15)
               send_item(random_load(int'($urandom_range(0, MAX_REGION_RECTS - 1))), ph != 2);
            else
               send_item(random_draw(), ph != 2);
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d transfers (%0d draws) over %0d register settings.",
               sent_items, sent_draws, phase_count);
      $display("Checked %0d result segments, %0d mismatches.", segment_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lce_pkg.sv
hw/rtl/lce_ctrl.sv
hw/rtl/lce_datapath.sv
hw/rtl/line_clip_engine_unit.sv
tb/lce_checker.sv
tb/tb_top.sv
